FILE: rtl/cwzp_pkg.sv
// package for the 2d convolution window engine with zero padding
// holds field widths, command and register codes, fsm states and control structs
// no dependencies
package cwzp_pkg;

    localparam int IMG_W_DEF = 64;
    localparam int IMG_H_DEF = 64;
    localparam int KMAX_DEF  = 7;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 12;
    localparam int VAL_W      = 16;
    localparam int CENTER_W   = 6;
    localparam int SUM_W      = 40;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int KW_W       = 3;
    localparam int IMG_DIM_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int TAP_W      = 3;
    localparam int COORD_W    = 8;

    localparam logic [KW_W-1:0]      KW_RESET = 3'd5;
    localparam logic [IMG_DIM_W-1:0] IW_RESET = 7'd48;
    localparam logic [IMG_DIM_W-1:0] IH_RESET = 7'd40;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_WEIGHT = 2'd0,
        CMD_WR_PIXEL  = 2'd1,
        CMD_COMPUTE   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_WIDTH = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             wr_weight;
        logic             wr_pixel;
        logic             start;
        logic             tap_valid;
        logic [TAP_W-1:0] tap_row;
        logic [TAP_W-1:0] tap_col;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic             busy;
        logic             out_free;
        logic [TAP_W-1:0] tap_max;
    } t_dp_status;

endpackage

FILE: rtl/cwzp_if.sv
// channel interfaces: input items, result items and configuration writes
// depends on cwzp_pkg for field widths
interface cwzp_in_if;
    logic                                valid;
    logic                                ready;
    logic [cwzp_pkg::CMD_W-1:0]          cmd;
    logic [cwzp_pkg::ADDR_W-1:0]         addr;
    logic signed [cwzp_pkg::VAL_W-1:0]   value;
    logic [cwzp_pkg::CENTER_W-1:0]       pos_x;
    logic [cwzp_pkg::CENTER_W-1:0]       pos_y;

    modport source (output valid, cmd, addr, value, pos_x, pos_y, input ready);
    modport sink (input valid, cmd, addr, value, pos_x, pos_y, output ready);
endinterface

interface cwzp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cwzp_pkg::SUM_W-1:0] window_sum;

    modport source (output valid, window_sum, input ready);
    modport sink (input valid, window_sum, output ready);
endinterface

interface cwzp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cwzp_pkg::CFG_IDX_W-1:0]     index;
    logic [cwzp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/conv2d_window_zero_pad_core.sv
// write items: one per cycle while idle, no result. compute items: (2h+1)^2 taps,
// one per cycle through the shared multiply-accumulate, h = (kernel_width-1)/2;
// the result register loads once the tap pipeline has drained, later while an
// earlier sum still waits, and the next item is taken the cycle after that load.
// each store has a single memory read port.
// synchronous active-low reset clears control and config; stores are not cleared
module conv2d_window_zero_pad_core #(
    parameter int IMG_W = cwzp_pkg::IMG_W_DEF,
    parameter int IMG_H = cwzp_pkg::IMG_H_DEF,
    parameter int KMAX  = cwzp_pkg::KMAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cwzp_in_if.sink     i_in,
    cwzp_out_if.source  o_out,
    cwzp_cfg_if.sink    i_cfg
);

    cwzp_pkg::t_dp_cmd    dp_cmd;
    cwzp_pkg::t_dp_status dp_status;

    cwzp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    cwzp_datapath #(
        .IMG_W (IMG_W),
        .IMG_H (IMG_H),
        .KMAX  (KMAX)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (i_in.addr),
        .i_value    (i_in.value),
        .i_pos_x    (i_in.pos_x),
        .i_pos_y    (i_in.pos_y),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

FILE: rtl/cwzp_datapath.sv
// datapath: config registers, weight and pixel memories, tap address stage,
// multiply stage, accumulator and result register; depends on cwzp_pkg and cwzp_if
module cwzp_datapath #(
    parameter int IMG_W = cwzp_pkg::IMG_W_DEF,
    parameter int IMG_H = cwzp_pkg::IMG_H_DEF,
    parameter int KMAX  = cwzp_pkg::KMAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [cwzp_pkg::ADDR_W-1:0]          i_addr,
    input  logic signed [cwzp_pkg::VAL_W-1:0]    i_value,
    input  logic [cwzp_pkg::CENTER_W-1:0]        i_pos_x,
    input  logic [cwzp_pkg::CENTER_W-1:0]        i_pos_y,
    input  cwzp_pkg::t_dp_cmd                    i_cmd,
    output cwzp_pkg::t_dp_status                 o_status,
    cwzp_cfg_if.sink                             i_cfg,
    cwzp_out_if.source                           o_out
);

    localparam int KDEPTH  = KMAX * KMAX;
    localparam int IDEPTH  = IMG_W * IMG_H;
    localparam int KADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int IADDR_W = $clog2(IDEPTH);

    logic [cwzp_pkg::KW_W-1:0]       r_kw;
    logic [cwzp_pkg::IMG_DIM_W-1:0]  r_iw;
    logic [cwzp_pkg::IMG_DIM_W-1:0]  r_ih;
    logic [cwzp_pkg::KW_W-1:0]       kw_eff;
    logic [cwzp_pkg::IMG_DIM_W-1:0]  iw_eff;
    logic [cwzp_pkg::IMG_DIM_W-1:0]  ih_eff;
    logic [cwzp_pkg::TAP_W-1:0]      half;

    logic signed [cwzp_pkg::VAL_W-1:0] r_kmem [KDEPTH];
    logic signed [cwzp_pkg::VAL_W-1:0] r_imem [IDEPTH];

    logic [cwzp_pkg::CENTER_W-1:0]   r_cx;
    logic [cwzp_pkg::CENTER_W-1:0]   r_cy;

    logic signed [cwzp_pkg::COORD_W-1:0] px;
    logic signed [cwzp_pkg::COORD_W-1:0] py;
    logic                            n_inb;
    logic [KADDR_W-1:0]              n_waddr;
    logic [IADDR_W-1:0]              n_paddr;

    logic                            r_v1;
    logic                            r_inb1;
    logic [KADDR_W-1:0]              r_waddr;
    logic [IADDR_W-1:0]              r_paddr;
    logic                            r_v2;
    logic                            r_inb2;
    logic signed [cwzp_pkg::VAL_W-1:0] r_wdata;
    logic signed [cwzp_pkg::VAL_W-1:0] r_pdata;
    logic                            r_v3;
    logic signed [cwzp_pkg::PROD_W-1:0] r_prod;
    logic signed [cwzp_pkg::SUM_W-1:0]  r_acc;
    logic                            r_out_valid;
    logic signed [cwzp_pkg::SUM_W-1:0]  r_out_sum;

    // configuration registers, writable at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= cwzp_pkg::KW_RESET;
            r_iw <= cwzp_pkg::IW_RESET;
            r_ih <= cwzp_pkg::IH_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == cwzp_pkg::CFG_KERNEL_WIDTH) begin
                r_kw <= i_cfg.data[cwzp_pkg::KW_W-1:0];
            end else if (i_cfg.index == cwzp_pkg::CFG_IMAGE_WIDTH) begin
                r_iw <= i_cfg.data[cwzp_pkg::IMG_DIM_W-1:0];
            end else if (i_cfg.index == cwzp_pkg::CFG_IMAGE_HEIGHT) begin
                r_ih <= i_cfg.data[cwzp_pkg::IMG_DIM_W-1:0];
            end
        end
    end

    // saturate to store sizes
    assign kw_eff = (32'(r_kw) > KMAX)  ? cwzp_pkg::KW_W'(KMAX)       : r_kw;
    assign iw_eff = (32'(r_iw) > IMG_W) ? cwzp_pkg::IMG_DIM_W'(IMG_W) : r_iw;
    assign ih_eff = (32'(r_ih) > IMG_H) ? cwzp_pkg::IMG_DIM_W'(IMG_H) : r_ih;
    assign half   = (kw_eff == '0) ? '0 : ((kw_eff - 3'd1) >> 1);

    assign o_status.tap_max  = half << 1;
    assign o_status.busy     = r_v1 | r_v2 | r_v3;
    assign o_status.out_free = !r_out_valid || o_out.ready;

    // weight and pixel stores, writes beyond the store are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight && (32'(i_addr) < KDEPTH)) begin
            r_kmem[KADDR_W'(i_addr)] <= i_value;
        end
        r_wdata <= r_kmem[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pixel && (32'(i_addr) < IDEPTH)) begin
            r_imem[IADDR_W'(i_addr)] <= i_value;
        end
        r_pdata <= r_imem[r_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx <= i_pos_x;
            r_cy <= i_pos_y;
        end
    end

    // tap coordinates and store addresses
    always_comb begin
        px = $signed(cwzp_pkg::COORD_W'(r_cx)) + $signed(cwzp_pkg::COORD_W'(i_cmd.tap_col))
             - $signed(cwzp_pkg::COORD_W'(half));
        py = $signed(cwzp_pkg::COORD_W'(r_cy)) + $signed(cwzp_pkg::COORD_W'(i_cmd.tap_row))
             - $signed(cwzp_pkg::COORD_W'(half));
        n_inb = !px[cwzp_pkg::COORD_W-1] && !py[cwzp_pkg::COORD_W-1]
                && (px < $signed(cwzp_pkg::COORD_W'(iw_eff)))
                && (py < $signed(cwzp_pkg::COORD_W'(ih_eff)));
        n_waddr = KADDR_W'(i_cmd.tap_row) * KADDR_W'(kw_eff) + KADDR_W'(i_cmd.tap_col);
        n_paddr = IADDR_W'(iw_eff) * IADDR_W'(py[cwzp_pkg::IMG_DIM_W-1:0])
                  + IADDR_W'(px[cwzp_pkg::IMG_DIM_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        r_inb1  <= n_inb;
        r_waddr <= n_waddr;
        r_paddr <= n_paddr;
        r_inb2  <= r_inb1;
        // out-of-image taps count as zero
        if (r_inb2) begin
            r_prod <= r_wdata * r_pdata;
        end else begin
            r_prod <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + cwzp_pkg::SUM_W'(r_prod);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sum <= r_acc;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_sum = r_out_sum;

endmodule

FILE: rtl/cwzp_ctrl.sv
// controller: takes input items, steps the tap counters over the window
// and hands the sum to the result register; depends on cwzp_pkg
module cwzp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [cwzp_pkg::CMD_W-1:0]   i_in_cmd,
    output logic                         o_in_ready,
    input  cwzp_pkg::t_dp_status         i_status,
    output cwzp_pkg::t_dp_cmd            o_cmd
);

    cwzp_pkg::t_state            r_state;
    cwzp_pkg::t_state            n_state;
    logic [cwzp_pkg::TAP_W-1:0]  r_row;
    logic [cwzp_pkg::TAP_W-1:0]  n_row;
    logic [cwzp_pkg::TAP_W-1:0]  r_col;
    logic [cwzp_pkg::TAP_W-1:0]  n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwzp_pkg::ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.tap_row = r_row;
        o_cmd.tap_col = r_col;
        case (r_state)
            cwzp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_weight = (i_in_cmd == cwzp_pkg::CMD_WR_WEIGHT);
                    o_cmd.wr_pixel  = (i_in_cmd == cwzp_pkg::CMD_WR_PIXEL);
                    if (i_in_cmd == cwzp_pkg::CMD_COMPUTE) begin
                        o_cmd.start = 1'b1;
                        n_row       = '0;
                        n_col       = '0;
                        n_state     = cwzp_pkg::ST_RUN;
                    end
                end
            end
            cwzp_pkg::ST_RUN: begin
                // one tap per cycle, row-major over the window
                o_cmd.tap_valid = 1'b1;
                if (r_col == i_status.tap_max) begin
                    n_col = '0;
                    if (r_row == i_status.tap_max) begin
                        n_state = cwzp_pkg::ST_DRAIN;
                    end else begin
                        n_row = r_row + 3'd1;
                    end
                end else begin
                    n_col = r_col + 3'd1;
                end
            end
            cwzp_pkg::ST_DRAIN: begin
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = cwzp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cwzp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
